FILE: rtl/ftws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftws_pkg
// Shared widths, codes and controller/datapath handshake types for the
// frame time window statistics block.
// ----------------------------------------------------------------------------
package ftws_pkg;

  localparam int unsigned MS_W    = 10;
  localparam int unsigned FRAME_W = 16;

  localparam logic [MS_W-1:0] MS_MIN = 10'd1;
  localparam logic [MS_W-1:0] MS_MAX = 10'd1000;

  localparam logic CMD_CLEAR  = 1'b0;
  localparam logic CMD_RECORD = 1'b1;

  typedef enum logic [1:0] {
    DIV_AVG,
    DIV_BEST,
    DIV_WORST
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     out_load;
  } ftws_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic div_done;
  } ftws_sts_t;

endpackage
`default_nettype wire

FILE: rtl/ftws_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftws_in_if
// Input channel: one frame command per transfer.
// ----------------------------------------------------------------------------
interface ftws_in_if import ftws_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [FRAME_W-1:0] frame_ms;

  modport source (output valid, output cmd, output frame_ms, input ready);
  modport sink (input valid, input cmd, input frame_ms, output ready);
endinterface
`default_nettype wire

FILE: rtl/ftws_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftws_out_if
// Result channel: window statistics, one transfer per command.
// ----------------------------------------------------------------------------
interface ftws_out_if import ftws_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [MS_W-1:0] avg_rate;
  logic [MS_W-1:0] best_excess;
  logic [MS_W-1:0] worst_deficit;
  logic [MS_W-1:0] newest_ms;

  modport source (
    output valid, output avg_rate, output best_excess,
    output worst_deficit, output newest_ms, input ready
  );
  modport sink (
    input valid, input avg_rate, input best_excess,
    input worst_deficit, input newest_ms, output ready
  );
endinterface
`default_nettype wire

FILE: rtl/ftws_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftws_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ftws_div import ftws_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic              done,
  output logic [W-1:0]      quo
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_r;
  logic [W-1:0]  q_r;
  logic [W-1:0]  den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  assign shifted = {rem_r, q_r[W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? diff[W-1:0] : shifted[W-1:0];
      q_r   <= {q_r[W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

FILE: rtl/ftws_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftws_dp
// Datapath: frame ring memory, window walk (sum, min, max), shared divider
// and result registers.
// ----------------------------------------------------------------------------
module ftws_dp import ftws_pkg::*; #(
  parameter int unsigned DEPTH = 60
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ftws_cmd_t          cmd_i,
  input  wire logic               in_cmd,
  input  wire logic [FRAME_W-1:0] in_frame_ms,
  output ftws_sts_t               sts_o,
  output logic [MS_W-1:0]         avg_rate,
  output logic [MS_W-1:0]         best_excess,
  output logic [MS_W-1:0]         worst_deficit,
  output logic [MS_W-1:0]         newest_ms
);

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned NUM = 1000 * DEPTH;
  localparam int unsigned TW  = $clog2(NUM + 1);

  logic [MS_W-1:0]  mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [AW-1:0]    wpos_r;
  logic [MS_W-1:0]  newest_r;

  logic [AW-1:0]    addr_r;
  logic             issue_r;
  logic             rd_pend_r;
  logic             rd_last_r;
  logic [MS_W-1:0]  rd_data_r;
  logic             rd_valid_r;

  logic [TW-1:0]    total_r;
  logic [MS_W-1:0]  min_r;
  logic [MS_W-1:0]  max_r;

  logic [TW-1:0]    avg_q_r;
  logic [TW-1:0]    best_q_r;
  logic [TW-1:0]    worst_q_r;

  logic [MS_W-1:0]  out_avg_r;
  logic [MS_W-1:0]  out_best_r;
  logic [MS_W-1:0]  out_worst_r;
  logic [MS_W-1:0]  out_newest_r;

  logic [MS_W-1:0]  clamped;
  logic [MS_W-1:0]  entry;
  logic             addr_last;
  logic [TW-1:0]    div_num;
  logic [TW-1:0]    div_den;
  logic             div_done;
  logic [TW-1:0]    div_quo;

  always_comb begin
    priority if (in_frame_ms == '0) begin
      clamped = MS_MIN;
    end else if (in_frame_ms > FRAME_W'(MS_MAX)) begin
      clamped = MS_MAX;
    end else begin
      clamped = in_frame_ms[MS_W-1:0];
    end
  end

  assign addr_last = addr_r == AW'(DEPTH - 1);
  assign entry     = rd_valid_r ? rd_data_r : MS_MIN;

  // ring state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      wpos_r   <= '0;
      newest_r <= MS_MIN;
    end else if (cmd_i.load) begin
      if (in_cmd == CMD_CLEAR) begin
        valid_r  <= '0;
        wpos_r   <= '0;
        newest_r <= MS_MIN;
      end else begin
        valid_r[wpos_r] <= 1'b1;
        wpos_r          <= (wpos_r == AW'(DEPTH - 1)) ? '0 : wpos_r + 1'b1;
        newest_r        <= clamped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load && in_cmd == CMD_RECORD) begin
      mem[wpos_r] <= clamped;
    end
    rd_data_r  <= mem[addr_r];
    rd_valid_r <= valid_r[addr_r];
  end

  // window walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r   <= 1'b0;
      rd_pend_r <= 1'b0;
      rd_last_r <= 1'b0;
      addr_r    <= '0;
    end else begin
      rd_pend_r <= issue_r;
      rd_last_r <= issue_r && addr_last;
      if (cmd_i.load) begin
        issue_r <= 1'b1;
        addr_r  <= '0;
      end else if (issue_r) begin
        if (addr_last) begin
          issue_r <= 1'b0;
        end else begin
          addr_r <= addr_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      total_r <= '0;
      min_r   <= MS_MAX;
      max_r   <= MS_MIN;
    end else if (rd_pend_r) begin
      total_r <= total_r + TW'(entry);
      if (entry < min_r) begin
        min_r <= entry;
      end
      if (entry > max_r) begin
        max_r <= entry;
      end
    end
  end

  // shared divider
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_AVG: begin
        div_num = TW'(NUM);
        div_den = total_r;
      end
      DIV_BEST: begin
        div_num = TW'(MS_MAX);
        div_den = TW'(min_r);
      end
      DIV_WORST: begin
        div_num = TW'(MS_MAX);
        div_den = TW'(max_r);
      end
      default: begin
        div_num = TW'(MS_MAX);
        div_den = TW'(MS_MAX);
      end
    endcase
  end

  ftws_div #(.W(TW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd_i.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (cmd_i.div_sel)
        DIV_AVG:   avg_q_r   <= div_quo;
        DIV_BEST:  best_q_r  <= div_quo;
        DIV_WORST: worst_q_r <= div_quo;
        default:   avg_q_r   <= div_quo;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_avg_r    <= avg_q_r[MS_W-1:0];
      out_best_r   <= best_q_r[MS_W-1:0] - avg_q_r[MS_W-1:0];
      out_worst_r  <= avg_q_r[MS_W-1:0] - worst_q_r[MS_W-1:0];
      out_newest_r <= newest_r;
    end
  end

  assign sts_o.walk_done = rd_pend_r && rd_last_r;
  assign sts_o.div_done  = div_done;

  assign avg_rate      = out_avg_r;
  assign best_excess   = out_best_r;
  assign worst_deficit = out_worst_r;
  assign newest_ms     = out_newest_r;

endmodule
`default_nettype wire

FILE: rtl/ftws_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftws_ctrl
// Controller: sequences ring update, window walk, three divisions and the
// result transfer.
// ----------------------------------------------------------------------------
module ftws_ctrl import ftws_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire ftws_sts_t sts_i,
  output ftws_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DIV_AVG,
    S_DIV_BEST,
    S_DIV_WORST,
    S_DONE
  } state_t;

  state_t   state_r;
  state_t   state_nxt;
  logic     in_ready_r;
  logic     in_ready_nxt;
  logic     out_valid_r;
  logic     out_valid_nxt;
  logic     div_start_r;
  logic     div_start_nxt;
  div_sel_t div_sel_r;
  div_sel_t div_sel_nxt;

  logic     load;
  logic     out_load;

  assign load     = in_valid && in_ready_r;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_start_nxt = 1'b0;
    div_sel_nxt   = div_sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (load) begin
          in_ready_nxt = 1'b0;
          state_nxt    = S_WALK;
        end else begin
          in_ready_nxt = 1'b1;
        end
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          div_start_nxt = 1'b1;
          div_sel_nxt   = DIV_AVG;
          state_nxt     = S_DIV_AVG;
        end
      end
      S_DIV_AVG: begin
        if (sts_i.div_done) begin
          div_start_nxt = 1'b1;
          div_sel_nxt   = DIV_BEST;
          state_nxt     = S_DIV_BEST;
        end
      end
      S_DIV_BEST: begin
        if (sts_i.div_done) begin
          div_start_nxt = 1'b1;
          div_sel_nxt   = DIV_WORST;
          state_nxt     = S_DIV_WORST;
        end
      end
      S_DIV_WORST: begin
        if (sts_i.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          in_ready_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      div_sel_r   <= DIV_AVG;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
      div_start_r <= div_start_nxt;
      div_sel_r   <= div_sel_nxt;
    end
  end

  assign in_ready        = in_ready_r;
  assign out_valid       = out_valid_r;
  assign cmd_o.load      = load;
  assign cmd_o.div_start = div_start_r;
  assign cmd_o.div_sel   = div_sel_r;
  assign cmd_o.out_load  = out_load;

endmodule
`default_nettype wire

FILE: rtl/frame_time_window_stats.sv
`default_nettype none
// input: one transfer at a time; the next input transfer is accepted only once
//   the result of the previous one has been loaded into the result register;
//   the pace is set by the one-entry-per-cycle ring walk and the bit-serial
//   divider shared by three divisions
// a waiting result does not block the next input transfer
// reset: synchronous, active low; ring entries read as 1 ms, write position zero
// ----------------------------------------------------------------------------
// frame_time_window_stats
// Sliding window frame-rate statistics over the last DEPTH frame times.
// ----------------------------------------------------------------------------
module frame_time_window_stats import ftws_pkg::*; #(
  parameter int unsigned DEPTH = 60
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ftws_in_if.sink     in_chan,
  ftws_out_if.source  out_chan
);

  ftws_cmd_t cmd;
  ftws_sts_t sts;

  ftws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ftws_dp #(.DEPTH(DEPTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (cmd),
    .in_cmd        (in_chan.cmd),
    .in_frame_ms   (in_chan.frame_ms),
    .sts_o         (sts),
    .avg_rate      (out_chan.avg_rate),
    .best_excess   (out_chan.best_excess),
    .worst_deficit (out_chan.worst_deficit),
    .newest_ms     (out_chan.newest_ms)
  );

endmodule
`default_nettype wire
